// ----- design/dfu_pkg.sv -----
package dfu_pkg;

    // Input selector codes
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_OVFL  = 2'd2;
    localparam logic [1:0] KIND_RDERR = 2'd3;

    // Receiver phases
    localparam logic [1:0] PH_DONE = 2'd0;
    localparam logic [1:0] PH_HUNT = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    // Link byte codes
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] DLE_CODE  = 8'h10;
    localparam logic [7:0] SUB_CODE  = 8'h1A;
    localparam logic [7:0] ETX_CODE  = 8'h03;

    // Room kept free at the end of the frame buffer
    localparam int ROOM_MARGIN = 5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [7:0] frame_length;
        logic       last;
    } result_t;

    // Up to two results produced by one request
    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ----- design/dfu_if.sv -----
interface dfu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface dfu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] frame_length;
    logic       last;

    modport source (output valid, output kind, output out_byte, output frame_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input frame_length,
                    input last, output ready);
endinterface

// ----- design/dle_frame_unstuffer.sv -----
// DLE frame unstuffer: receive side of one control frame on a DLE-shielded
// byte link.
// Input channel in_ch carries one request per link event: a received byte,
// a start of a new frame hunt, or a link read failure. Output channel out_ch
// carries result items: destuffed data bytes, frame complete with its
// length, overflow error, or read failure; last marks the final result of
// each request.
// Latency: with the result queue empty, the first result of a request is on
// out_ch the cycle after the request is accepted. Throughput: one request
// per cycle while the queue has two free entries; all decoding is done in
// one pass between the input handshake and a four-entry result queue.
// A DLE SUB pair gives two results. The input is ready whenever the queue
// has two free entries; the DLE ahead of SUB gives no result, so with a
// receiver taking one result per cycle the queue never holds more than two
// entries and the input never stalls.
// When the receiver stalls, results stay queued and the input drops ready
// once fewer than two entries are free; nothing is lost.
// Reset puts the block in the done phase (bytes ignored until a start
// request) and empties the result queue.
module dle_frame_unstuffer #(
    parameter int FRAME_BYTES = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    dfu_in_if.sink    in_ch,
    dfu_out_if.source out_ch
);

    localparam logic [7:0] LIMIT = 8'(FRAME_BYTES - dfu_pkg::ROOM_MARGIN);

    logic [1:0]       phase_reg, phase_next;
    logic             esc_reg, esc_next;
    logic [7:0]       count_reg, count_next;
    logic             accept;
    logic             active;
    logic             room;
    logic             head_valid;
    logic [7:0]       count_p1;
    logic [7:0]       count_p2;
    dfu_pkg::push_t   push;
    dfu_pkg::result_t head;

    assign accept   = in_ch.valid && in_ch.ready;
    assign active   = (phase_reg == dfu_pkg::PH_HUNT) || (phase_reg == dfu_pkg::PH_RECV);
    assign count_p1 = count_reg + 8'd1;
    assign count_p2 = count_reg + 8'd2;

    // Request decode and destuffing
    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        count_next = count_reg;
        push       = '0;
        if (accept)
        begin
            unique case (in_ch.action)
                dfu_pkg::ACT_START:
                begin
                    phase_next = dfu_pkg::PH_HUNT;
                    esc_next   = 1'b0;
                    count_next = 8'd0;
                end
                dfu_pkg::ACT_FAIL:
                begin
                    if (active)
                    begin
                        phase_next = dfu_pkg::PH_DONE;
                        push.n     = 2'd1;
                        push.first = '{dfu_pkg::KIND_RDERR, 8'd0, count_reg, 1'b1};
                    end
                end
                dfu_pkg::ACT_BYTE:
                begin
                    if (phase_reg == dfu_pkg::PH_HUNT)
                    begin
                        if (in_ch.data_byte == dfu_pkg::SYNC_BYTE)
                        begin
                            phase_next = dfu_pkg::PH_RECV;
                        end
                    end
                    else if (phase_reg == dfu_pkg::PH_RECV)
                    begin
                        priority if (count_reg >= LIMIT)
                        begin
                            phase_next = dfu_pkg::PH_DONE;
                            push.n     = 2'd1;
                            push.first = '{dfu_pkg::KIND_OVFL, 8'd0, count_reg, 1'b1};
                        end
                        else if (esc_reg)
                        begin
                            esc_next = 1'b0;
                            priority if (in_ch.data_byte == dfu_pkg::DLE_CODE)
                            begin
                                count_next = count_p1;
                                push.n     = 2'd1;
                                push.first = '{dfu_pkg::KIND_DATA, dfu_pkg::DLE_CODE,
                                               count_p1, 1'b1};
                            end
                            else if (in_ch.data_byte == dfu_pkg::SUB_CODE)
                            begin
                                count_next  = count_p2;
                                push.n      = 2'd2;
                                push.first  = '{dfu_pkg::KIND_DATA, dfu_pkg::DLE_CODE,
                                                count_p1, 1'b0};
                                push.second = '{dfu_pkg::KIND_DATA, dfu_pkg::DLE_CODE,
                                                count_p2, 1'b1};
                            end
                            else if (in_ch.data_byte == dfu_pkg::ETX_CODE)
                            begin
                                phase_next = dfu_pkg::PH_DONE;
                                push.n     = 2'd1;
                                push.first = '{dfu_pkg::KIND_END, 8'd0, count_reg, 1'b1};
                            end
                            else
                            begin
                                // unknown escape: byte dropped
                                push.n = 2'd0;
                            end
                        end
                        else if (in_ch.data_byte == dfu_pkg::DLE_CODE)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_p1;
                            push.n     = 2'd1;
                            push.first = '{dfu_pkg::KIND_DATA, in_ch.data_byte,
                                           count_p1, 1'b1};
                        end
                    end
                end
                default:
                begin
                    // unused selector: ignored
                    push.n = 2'd0;
                end
            endcase
        end
    end

    // Receiver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dfu_pkg::PH_DONE;
            esc_reg   <= 1'b0;
            count_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
        end
    end

    // Result queue
    dfu_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .pop        (out_ch.valid && out_ch.ready),
        .head_valid (head_valid),
        .head       (head)
    );

    assign in_ch.ready         = room;
    assign out_ch.valid        = head_valid;
    assign out_ch.kind         = head.kind;
    assign out_ch.out_byte     = head.out_byte;
    assign out_ch.frame_length = head.frame_length;
    assign out_ch.last         = head.last;

`ifndef SYNTHESIS
    // Results only come from an armed receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> active)
        else $error("result produced while receiver done");

    // Frame end, overflow and read failure all leave the receiver done
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0 && push.first.kind != dfu_pkg::KIND_DATA)
        |=> (phase_reg == dfu_pkg::PH_DONE))
        else $error("receiver still armed after terminal result");

    // Stored count never passes the limit by more than one DLE SUB pair
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT + 8'd1)
        else $error("stored count beyond buffer limit");
`endif

endmodule

// ----- design/dfu_result_fifo.sv -----
module dfu_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  dfu_pkg::push_t   push,
    output logic             room,
    input  logic             pop,
    output logic             head_valid,
    output dfu_pkg::result_t head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    dfu_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic [PW-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);

    // Two free slots are needed to take any request
    assign room       = (count_reg <= (PW+1)'(DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.n);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push.n) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

// ----- test/tb_dle_frame_unstuffer.sv -----
module tb_dle_frame_unstuffer;

    localparam int FRAME_BYTES  = 256;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;
    localparam int MAX_GAP      = 30;

    // Selector value with no meaning; the block must ignore it
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam dfu_pkg::result_t NO_RESULT = '0;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        logic [1:0]       act;
        logic [7:0]       b;
        logic             typed;
        logic [1:0]       n;
        dfu_pkg::result_t r;
    } row_t;

    localparam int DIR_ROWS = 28;

    localparam row_t DIRECTED [DIR_ROWS] = '{
        // after reset: everything but a start is ignored
        '{dfu_pkg::ACT_BYTE,  8'h00, 1'b1, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_FAIL,  8'hFF, 1'b1, 2'd0, NO_RESULT},
        '{ACT_NONE,           8'h5A, 1'b1, 2'd0, NO_RESULT},
        // hunt, restart while hunting, failure during hunt
        '{dfu_pkg::ACT_START, 8'hA5, 1'b1, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h10, 1'b1, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_START, 8'h00, 1'b1, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_FAIL,  8'h00, 1'b1, 2'd1,
          '{dfu_pkg::KIND_RDERR, 8'h00, 8'd0, 1'b1}},
        // sync, then extreme data bytes
        '{dfu_pkg::ACT_START, 8'hFF, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'hFF, 1'b1, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h00, 1'b1, 2'd1,
          '{dfu_pkg::KIND_DATA, 8'h00, 8'd1, 1'b1}},
        '{dfu_pkg::ACT_BYTE,  8'hFF, 1'b1, 2'd1,
          '{dfu_pkg::KIND_DATA, 8'hFF, 8'd2, 1'b1}},
        // escaped DLE, DLE SUB doubling, dropped escape, unused selector, read failure
        '{dfu_pkg::ACT_BYTE,  8'h10, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h10, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h10, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h1A, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h10, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h55, 1'b0, 2'd0, NO_RESULT},
        '{ACT_NONE,           8'hAA, 1'b1, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_FAIL,  8'h33, 1'b0, 2'd0, NO_RESULT},
        // plain ETX passes, start while escaped, empty frame end
        '{dfu_pkg::ACT_START, 8'h12, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'hFF, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h03, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h10, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_START, 8'hC3, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'hFF, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h10, 1'b0, 2'd0, NO_RESULT},
        '{dfu_pkg::ACT_BYTE,  8'h03, 1'b1, 2'd1,
          '{dfu_pkg::KIND_END, 8'h00, 8'd0, 1'b1}},
        // bytes after the end are ignored
        '{dfu_pkg::ACT_BYTE,  8'h42, 1'b1, 2'd0, NO_RESULT}
    };

    logic clk;
    logic rst_n;

    dfu_in_if  in_ch ();
    dfu_out_if out_ch ();

    dle_frame_unstuffer #(.FRAME_BYTES(FRAME_BYTES)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state
    logic [1:0] model_phase;
    logic       model_escaped;
    logic [7:0] model_count;

    dfu_pkg::result_t pending_results [$];

    int   idle_mode;
    logic stall_hold;
    event hold_kick;

    int fail_count;
    int cycle_count;
    int items_sent;
    int frames_sent;
    int data_seen;
    int end_seen;
    int ovfl_seen;
    int rderr_seen;
    dfu_pkg::result_t want_r;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int send_idle_pct();
        case (idle_mode)
            1: return 74;
            3: return 36;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            2: return 74;
            3: return 36;
            default: return 0;
        endcase
    endfunction

    // Destuffing predictor: advances the state by one request
    function automatic int unstuff_step(input logic [1:0] act, input logic [7:0] b,
                                        output dfu_pkg::result_t r0,
                                        output dfu_pkg::result_t r1);
        logic active;
        active = (model_phase == dfu_pkg::PH_HUNT) || (model_phase == dfu_pkg::PH_RECV);
        r0 = NO_RESULT;
        r1 = NO_RESULT;
        if (act == dfu_pkg::ACT_START)
        begin
            model_phase   = dfu_pkg::PH_HUNT;
            model_escaped = 1'b0;
            model_count   = 8'd0;
            return 0;
        end
        if (act == dfu_pkg::ACT_FAIL)
        begin
            if (!active)
                return 0;
            model_phase = dfu_pkg::PH_DONE;
            r0 = '{dfu_pkg::KIND_RDERR, 8'h00, model_count, 1'b1};
            return 1;
        end
        if (act != dfu_pkg::ACT_BYTE || !active)
            return 0;
        if (model_phase == dfu_pkg::PH_HUNT)
        begin
            if (b == dfu_pkg::SYNC_BYTE)
                model_phase = dfu_pkg::PH_RECV;
            return 0;
        end
        // room check comes before every byte after sync
        if (int'(model_count) >= FRAME_BYTES - dfu_pkg::ROOM_MARGIN)
        begin
            model_phase = dfu_pkg::PH_DONE;
            r0 = '{dfu_pkg::KIND_OVFL, 8'h00, model_count, 1'b1};
            return 1;
        end
        if (model_escaped)
        begin
            model_escaped = 1'b0;
            if (b == dfu_pkg::DLE_CODE)
            begin
                model_count = model_count + 8'd1;
                r0 = '{dfu_pkg::KIND_DATA, dfu_pkg::DLE_CODE, model_count, 1'b1};
                return 1;
            end
            if (b == dfu_pkg::SUB_CODE)
            begin
                model_count = model_count + 8'd1;
                r0 = '{dfu_pkg::KIND_DATA, dfu_pkg::DLE_CODE, model_count, 1'b0};
                model_count = model_count + 8'd1;
                r1 = '{dfu_pkg::KIND_DATA, dfu_pkg::DLE_CODE, model_count, 1'b1};
                return 2;
            end
            if (b == dfu_pkg::ETX_CODE)
            begin
                model_phase = dfu_pkg::PH_DONE;
                r0 = '{dfu_pkg::KIND_END, 8'h00, model_count, 1'b1};
                return 1;
            end
            return 0;
        end
        if (b == dfu_pkg::DLE_CODE)
        begin
            model_escaped = 1'b1;
            return 0;
        end
        model_count = model_count + 8'd1;
        r0 = '{dfu_pkg::KIND_DATA, b, model_count, 1'b1};
        return 1;
    endfunction

    // Offer one request, wait for acceptance, queue what it should produce
    task automatic offer_request(input row_t rw);
        int gap;
        int n;
        dfu_pkg::result_t r0;
        dfu_pkg::result_t r1;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct())
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= rw.act;
        in_ch.data_byte <= rw.b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n = unstuff_step(rw.act, rw.b, r0, r1);
        if (rw.typed)
        begin
            if (rw.n != 2'd0)
                pending_results.push_back(rw.r);
        end
        else
        begin
            if (n > 0)
                pending_results.push_back(r0);
            if (n > 1)
                pending_results.push_back(r1);
        end
        items_sent++;
    endtask

    task automatic send_request(input logic [1:0] act, input logic [7:0] b);
        row_t rw;
        rw = '{act, b, 1'b0, 2'd0, NO_RESULT};
        offer_request(rw);
    endtask

    // Sender goes quiet until every queued result has been taken
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One frame: start, noise, sync, stuffed payload, mostly an ending, then trailing traffic; a few fail before sync
    task automatic send_frame();
        int target;
        int pick;
        logic [7:0] b;
        logic [1:0] act;
        send_request(dfu_pkg::ACT_START, 8'($urandom_range(255)));
        repeat ($urandom_range(3))
        begin
            b = 8'($urandom_range(254));
            send_request(dfu_pkg::ACT_BYTE, b);
        end
        if ($urandom_range(99) < 3)
        begin
            send_request(dfu_pkg::ACT_FAIL, 8'($urandom_range(255)));
            return;
        end
        send_request(dfu_pkg::ACT_BYTE, dfu_pkg::SYNC_BYTE);
        // mostly short frames, a few that run into the room limit
        if ($urandom_range(99) < 5)
            target = $urandom_range(258, 245);
        else
            target = $urandom_range(24);
        while (model_phase == dfu_pkg::PH_RECV && int'(model_count) < target)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_request(dfu_pkg::ACT_BYTE, dfu_pkg::DLE_CODE);
                send_request(dfu_pkg::ACT_BYTE, dfu_pkg::DLE_CODE);
            end
            else if (pick < 12)
            begin
                send_request(dfu_pkg::ACT_BYTE, dfu_pkg::DLE_CODE);
                send_request(dfu_pkg::ACT_BYTE, dfu_pkg::SUB_CODE);
            end
            else if (pick < 16)
            begin
                b = 8'($urandom_range(255));
                if (b == dfu_pkg::ETX_CODE)
                    b = 8'h04;
                send_request(dfu_pkg::ACT_BYTE, dfu_pkg::DLE_CODE);
                send_request(dfu_pkg::ACT_BYTE, b);
            end
            else if (pick < 19)
                send_request(ACT_NONE, 8'($urandom_range(255)));
            else if (pick < 21)
                send_request(dfu_pkg::ACT_BYTE, dfu_pkg::ETX_CODE);
            else if (pick < 23)
                send_request(dfu_pkg::ACT_BYTE, dfu_pkg::SUB_CODE);
            else
                send_request(dfu_pkg::ACT_BYTE, 8'($urandom_range(255)));
        end
        if (model_phase == dfu_pkg::PH_RECV)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                if (!model_escaped)
                    send_request(dfu_pkg::ACT_BYTE, dfu_pkg::DLE_CODE);
                send_request(dfu_pkg::ACT_BYTE, dfu_pkg::ETX_CODE);
            end
            else if (pick < 90)
                send_request(dfu_pkg::ACT_FAIL, 8'($urandom_range(255)));
        end
        // trailing traffic, ignored once done
        repeat ($urandom_range(2))
        begin
            act = 2'($urandom_range(2));
            if (act == dfu_pkg::ACT_START)
                act = ACT_NONE;
            send_request(act, 8'($urandom_range(255)));
        end
    endtask

    // Long receiver hold-off, counted here
    initial
    begin
        stall_hold = 1'b0;
        forever
        begin
            @(hold_kick);
            stall_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            stall_hold <= 1'b0;
        end
    end

    // Result checker and receiver ready
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: kind=%0d byte=%02h len=%0d last=%0b",
                             out_ch.kind, out_ch.out_byte, out_ch.frame_length, out_ch.last);
            end
            else
            begin
                want_r = pending_results.pop_front();
                if (want_r.kind !== out_ch.kind || want_r.out_byte !== out_ch.out_byte ||
                    want_r.frame_length !== out_ch.frame_length ||
                    want_r.last !== out_ch.last)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"mismatch: want kind=%0d byte=%02h len=%0d last=%0b, ",
                                  "got kind=%0d byte=%02h len=%0d last=%0b"},
                                 want_r.kind, want_r.out_byte, want_r.frame_length,
                                 want_r.last, out_ch.kind, out_ch.out_byte,
                                 out_ch.frame_length, out_ch.last);
                end
                case (want_r.kind)
                    dfu_pkg::KIND_DATA: data_seen++;
                    dfu_pkg::KIND_END:  end_seen++;
                    dfu_pkg::KIND_OVFL: ovfl_seen++;
                    default:            rderr_seen++;
                endcase
            end
        end
        if (!rst_n || stall_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct());
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[dle_frame_unstuffer] ERROR");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        in_ch.valid     <= 1'b0;
        in_ch.action    <= dfu_pkg::ACT_BYTE;
        in_ch.data_byte <= 8'h00;
        rst_n = 1'b0;
        model_phase   = dfu_pkg::PH_DONE;
        model_escaped = 1'b0;
        model_count   = 8'd0;
        idle_mode   = 0;
        fail_count  = 0;
        cycle_count = 0;
        items_sent  = 0;
        frames_sent = 0;
        data_seen   = 0;
        end_seen    = 0;
        ovfl_seen   = 0;
        rderr_seen  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            offer_request(DIRECTED[i]);
        pause_until_drained();

        // random frames, idling mode steps through four phases
        while (items_sent < DIR_ROWS + RANDOM_ITEMS)
        begin
            idle_mode = (items_sent - DIR_ROWS) * 4 / RANDOM_ITEMS;
            if (idle_mode > 3)
                idle_mode = 3;
            if (frames_sent == 0)
                -> hold_kick;
            if (frames_sent == 3 || $urandom_range(99) < 5)
                pause_until_drained();
            send_frame();
            frames_sent++;
        end

        // wait for the last results, then let the bench idle before the summary
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests in %0d random frames plus the directed table",
                 items_sent, frames_sent);
        $display("checked %0d data, %0d end, %0d overflow, %0d read-failure results",
                 data_seen, end_seen, ovfl_seen, rderr_seen);
        if (fail_count == 0)
            $display("[dle_frame_unstuffer] OK");
        else
            $display("[dle_frame_unstuffer] ERROR");
        $finish;
    end

endmodule
